[rtl/xcrc_pkg.sv]
package xcrc_pkg;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NUMBER,
      PH_COMPL,
      PH_DATA,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_DONE
   } phase_type;

   localparam logic [1:0] MODE_BYTE    = 2'd0;
   localparam logic [1:0] MODE_TIMEOUT = 2'd1;
   localparam logic [1:0] MODE_START   = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   localparam logic [1:0] SESSION_RUNNING = 2'd0;
   localparam logic [1:0] SESSION_DONE    = 2'd1;
   localparam logic [1:0] SESSION_ABORTED = 2'd2;

   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_MAX_ERRORS   = 1'b1;

   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_ASK = 8'h43;

   localparam logic [7:0]  ERROR_MAX   = 8'd255;
   localparam logic [8:0]  NUMBER_SUM  = 9'd255;
   localparam logic [10:0] SHORT_BLOCK = 11'd128;
   localparam logic [10:0] LONG_BLOCK  = 11'd1024;
   localparam logic [15:0] CRC_POLY    = 16'h1021;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        wr_valid;
      logic [31:0] wr_address;
      logic [7:0]  wr_data;
      logic [1:0]  session;
      logic [31:0] file_size;
      logic        twice;   // result goes out twice, first copy not last
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[rtl/xcrc_engine.sv]
module xcrc_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [1:0]          mode,
   input  logic [7:0]          rx_byte,
   input  logic [31:0]         base_address,
   input  logic [7:0]          max_errors,
   output xcrc_pkg::result_type result
);
   import xcrc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        long_block_ff, long_block_in;
   logic [10:0] byte_index_ff, byte_index_in;
   logic [7:0]  expected_ff, expected_in;
   logic [7:0]  got_number_ff, got_number_in;
   logic [7:0]  got_compl_ff, got_compl_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  got_crc_hi_ff, got_crc_hi_in;
   logic [31:0] address_ff, address_in;
   logic [31:0] total_ff, total_in;
   logic [7:0]  errors_ff, errors_in;
   logic        seen_ff, seen_in;
   logic [1:0]  session_ff, session_in;

   logic        active, ask, is_byte, hdr, hdr_open, hdr_eot, hdr_can;
   logic        data_byte, crc_lo, crc_good, do_fail, at_limit;
   logic [7:0]  errors_inc;
   logic [8:0]  number_sum;
   logic [10:0] block_size, index_next;

   // decode of the current request against the state
   always_comb begin
      active     = (mode != MODE_START) && (mode != MODE_UNUSED) &&
                   (session_ff == SESSION_RUNNING) && (phase_ff != PH_DONE);
      ask        = active && (mode == MODE_TIMEOUT) && (phase_ff == PH_HEADER) && !seen_ff;
      is_byte    = active && (mode == MODE_BYTE);
      hdr        = is_byte && (phase_ff == PH_HEADER);
      hdr_open   = hdr && ((rx_byte == BYTE_SOH) || (rx_byte == BYTE_STX));
      hdr_eot    = hdr && (rx_byte == BYTE_EOT);
      hdr_can    = hdr && (rx_byte == BYTE_CAN);
      data_byte  = is_byte && (phase_ff == PH_DATA);
      crc_lo     = is_byte && (phase_ff == PH_CRC_LO);
      number_sum = {1'b0, got_number_ff} + {1'b0, got_compl_ff};
      crc_good   = crc_lo && (got_number_ff == expected_ff) && (number_sum == NUMBER_SUM) &&
                   ({got_crc_hi_ff, rx_byte} == crc_ff);
      do_fail    = (active && (mode == MODE_TIMEOUT) && !ask) ||
                   (hdr && !hdr_open && !hdr_eot && !hdr_can) || (crc_lo && !crc_good);
      errors_inc = (errors_ff == ERROR_MAX) ? errors_ff : errors_ff + 8'd1;
      at_limit   = errors_inc >= max_errors;
      block_size = long_block_ff ? LONG_BLOCK : SHORT_BLOCK;
      index_next = byte_index_ff + 11'd1;
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      long_block_in = long_block_ff;
      byte_index_in = byte_index_ff;
      expected_in   = expected_ff;
      got_number_in = got_number_ff;
      got_compl_in  = got_compl_ff;
      crc_in        = crc_ff;
      got_crc_hi_in = got_crc_hi_ff;
      address_in    = address_ff;
      total_in      = total_ff;
      errors_in     = errors_ff;
      seen_in       = seen_ff;
      session_in    = session_ff;
      if (mode == MODE_START) begin
         phase_in      = PH_HEADER;
         long_block_in = 1'b0;
         byte_index_in = '0;
         expected_in   = 8'd1;
         got_number_in = '0;
         got_compl_in  = '0;
         crc_in        = '0;
         got_crc_hi_in = '0;
         address_in    = base_address;
         total_in      = '0;
         errors_in     = '0;
         seen_in       = 1'b0;
         session_in    = SESSION_RUNNING;
      end else if (do_fail) begin
         errors_in = errors_inc;
         if (at_limit) begin
            session_in = SESSION_ABORTED;
            phase_in   = PH_DONE;
         end else begin
            phase_in = PH_HEADER;
         end
      end else if (hdr_open) begin
         long_block_in = (rx_byte == BYTE_STX);
         seen_in       = 1'b1;
         byte_index_in = '0;
         crc_in        = '0;
         phase_in      = PH_NUMBER;
      end else if (hdr_eot) begin
         session_in = SESSION_DONE;
         phase_in   = PH_DONE;
      end else if (hdr_can) begin
         session_in = SESSION_ABORTED;
         phase_in   = PH_DONE;
      end else if (is_byte && (phase_ff == PH_NUMBER)) begin
         got_number_in = rx_byte;
         phase_in      = PH_COMPL;
      end else if (is_byte && (phase_ff == PH_COMPL)) begin
         got_compl_in = rx_byte;
         phase_in     = PH_DATA;
      end else if (data_byte) begin
         crc_in        = crc_byte(crc_ff, rx_byte);
         byte_index_in = index_next;
         if (index_next >= block_size) begin
            phase_in = PH_CRC_HI;
         end
      end else if (is_byte && (phase_ff == PH_CRC_HI)) begin
         got_crc_hi_in = rx_byte;
         phase_in      = PH_CRC_LO;
      end else if (crc_good) begin
         expected_in = expected_ff + 8'd1;
         address_in  = address_ff + {21'd0, block_size};
         total_in    = total_ff + {21'd0, block_size};
         phase_in    = PH_HEADER;
      end
   end

   // result for the request
   always_comb begin
      result           = '0;
      result.session   = session_in;
      result.file_size = total_in;
      if (ask) begin
         result.tx_valid = 1'b1;
         result.tx_byte  = BYTE_ASK;
      end else if (do_fail) begin
         result.tx_valid = 1'b1;
         result.tx_byte  = at_limit ? BYTE_CAN : BYTE_NAK;
         result.twice    = at_limit;
      end else if (hdr_eot || crc_good) begin
         result.tx_valid = 1'b1;
         result.tx_byte  = BYTE_ACK;
      end else if (data_byte) begin
         result.wr_valid   = 1'b1;
         result.wr_address = address_ff + {21'd0, byte_index_ff};
         result.wr_data    = rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         long_block_ff <= 1'b0;
         byte_index_ff <= '0;
         expected_ff   <= 8'd1;
         got_number_ff <= '0;
         got_compl_ff  <= '0;
         crc_ff        <= '0;
         got_crc_hi_ff <= '0;
         address_ff    <= '0;
         total_ff      <= '0;
         errors_ff     <= '0;
         seen_ff       <= 1'b0;
         session_ff    <= SESSION_RUNNING;
      end else if (step) begin
         phase_ff      <= phase_in;
         long_block_ff <= long_block_in;
         byte_index_ff <= byte_index_in;
         expected_ff   <= expected_in;
         got_number_ff <= got_number_in;
         got_compl_ff  <= got_compl_in;
         crc_ff        <= crc_in;
         got_crc_hi_ff <= got_crc_hi_in;
         address_ff    <= address_in;
         total_ff      <= total_in;
         errors_ff     <= errors_in;
         seen_ff       <= seen_in;
         session_ff    <= session_in;
      end
   end

endmodule

[rtl/xmodem_crc_receiver.sv]
// XMODEM-CRC receiver. One request (host byte, timeout, or start of a new transfer) can
// be taken every clock cycle unless the result buffer is full and not draining; it is
// captured in an input register, handled by the protocol engine (CRC-16 update of a data
// byte included) and queued in a two-entry result buffer. Each request gives one response,
// except an abort at the error limit, which gives two CAN responses one after the other
// from one buffer entry; the buffer drain rate of one response per cycle while rsp_ready
// is high sets throughput. The user writes configuration (base address, error limit)
// through the csr port only while no transfer step is in flight; the block does not
// enforce this. base_address takes effect at the next start request.
module xmodem_crc_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_wr_valid,
   output logic [31:0] rsp_wr_address,
   output logic [7:0]  rsp_wr_data,
   output logic [1:0]  rsp_session,
   output logic [31:0] rsp_file_size,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import xcrc_pkg::*;

   logic [31:0] base_address_ff;
   logic [7:0]  max_errors_ff;

   logic        in_valid_ff;
   logic [1:0]  in_mode_ff;
   logic [7:0]  in_byte_ff;

   result_type  fifo_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        second_ff;

   result_type  result, head;
   logic        step, pop, rsp_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= '0;
         max_errors_ff   <= 8'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_address_ff <= csr_wdata;
            CSR_MAX_ERRORS:   max_errors_ff   <= csr_wdata[7:0];
            default:          ;
         endcase
      end
   end

   assign head     = fifo_ff[rd_ptr_ff];
   assign rsp_fire = rsp_valid && rsp_ready;
   // the doubled CAN entry leaves only after its second copy
   assign pop      = rsp_fire && (!head.twice || second_ff);
   assign step     = in_valid_ff && ((count_ff != 2'd2) || pop);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_rx_byte;
      end
   end

   xcrc_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .mode         (in_mode_ff),
      .rx_byte      (in_byte_ff),
      .base_address (base_address_ff),
      .max_errors   (max_errors_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (step) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
         second_ff <= 1'b0;
      end else begin
         if (step) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (step && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !step) begin
            count_ff <= count_ff - 2'd1;
         end
         if (rsp_fire) begin
            second_ff <= head.twice && !second_ff;
         end
      end
   end

   assign rsp_valid      = (count_ff != 2'd0);
   assign rsp_tx_valid   = head.tx_valid;
   assign rsp_tx_byte    = head.tx_byte;
   assign rsp_wr_valid   = head.wr_valid;
   assign rsp_wr_address = head.wr_address;
   assign rsp_wr_data    = head.wr_data;
   assign rsp_session    = head.session;
   assign rsp_file_size  = head.file_size;
   assign rsp_last       = !(head.twice && !second_ff);

endmodule

[rtl/xcrc_checker.sv]
module xcrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_tx_valid,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_wr_valid,
   input logic [1:0]  rsp_session,
   input logic        rsp_last
);
   import xcrc_pkg::*;

   // nothing left in the result buffer right after reset
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");

   // only the abort pair has a response that is not last
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |->
         (rsp_tx_valid && (rsp_tx_byte == BYTE_CAN) && (rsp_session == SESSION_ABORTED)))
      else $error("non-last response is not an abort CAN");

   // second CAN follows at once
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && rsp_last && rsp_tx_valid && (rsp_tx_byte == BYTE_CAN)))
      else $error("second CAN missing after first");

   // a response never both replies and writes flash
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tx_valid && rsp_wr_valid))
      else $error("response carries both reply and flash write");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind xmodem_crc_receiver xcrc_checker u_checker (.*);

[test/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import xcrc_pkg::*;

   localparam int ITEM_GOAL = 1750;
   localparam int PHASES = 3;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        wr_valid;
      logic [31:0] wr_address;
      logic [7:0]  wr_data;
      logic [1:0]  session;
      logic [31:0] file_size;
      logic        last;
   } reply_type;

   typedef enum logic [2:0] {
      FAULT_NONE,
      FAULT_NUMBER,
      FAULT_REPEAT,
      FAULT_COMPLEMENT,
      FAULT_CRC,
      FAULT_TIMEOUT
   } block_fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_wr_valid;
   logic [31:0] rsp_wr_address;
   logic [7:0]  rsp_wr_data;
   logic [1:0]  rsp_session;
   logic [31:0] rsp_file_size;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_BASE_ADDRESS;
   logic [31:0] csr_wdata = 32'h0;

   // receiver state as seen by the predictor
   logic [31:0] cfg_base;
   logic [7:0]  cfg_max_errors;
   phase_type   rx_phase;
   logic        blk_long;
   logic [10:0] blk_index;
   logic [7:0]  next_number;
   logic [7:0]  hdr_number;
   logic [7:0]  hdr_complement;
   logic [15:0] crc_calc;
   logic [15:0] crc_rx;
   logic [31:0] flash_addr;
   logic [31:0] total_bytes;
   logic [7:0]  err_count;
   logic        header_seen;
   logic [1:0]  end_state;

   reply_type pending [2];
   int        pending_n;
   reply_type reply_queue [$];

   int request_count = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int ready_hold = 0;
   bit gapless = 1'b0;

   xmodem_crc_receiver i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_wr_valid   (rsp_wr_valid),
      .rsp_wr_address (rsp_wr_address),
      .rsp_wr_data    (rsp_wr_data),
      .rsp_session    (rsp_session),
      .rsp_file_size  (rsp_file_size),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ data[i];
         c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void restart_transfer();
      rx_phase = PH_HEADER;
      blk_long = 1'b0;
      blk_index = '0;
      next_number = 8'd1;
      hdr_number = '0;
      hdr_complement = '0;
      crc_calc = '0;
      crc_rx = '0;
      flash_addr = cfg_base;
      total_bytes = '0;
      err_count = '0;
      header_seen = 1'b0;
      end_state = SESSION_RUNNING;
   endfunction

   function automatic void note_reply(input logic txv, input logic [7:0] txb, input logic wrv,
                                      input logic [31:0] addr, input logic [7:0] data);
      reply_type r;
      r = '0;
      r.tx_valid = txv;
      r.tx_byte = txv ? txb : 8'h00;
      r.wr_valid = wrv;
      r.wr_address = wrv ? addr : 32'h0;
      r.wr_data = wrv ? data : 8'h00;
      pending[pending_n] = r;
      pending_n++;
   endfunction

   function automatic void count_error();
      if (err_count != ERROR_MAX)
         err_count++;
      if (err_count >= cfg_max_errors) begin
         note_reply(1'b1, BYTE_CAN, 1'b0, 32'h0, 8'h00);
         note_reply(1'b1, BYTE_CAN, 1'b0, 32'h0, 8'h00);
         end_state = SESSION_ABORTED;
         rx_phase = PH_DONE;
      end else begin
         note_reply(1'b1, BYTE_NAK, 1'b0, 32'h0, 8'h00);
         rx_phase = PH_HEADER;
      end
   endfunction

   function automatic void take_byte(input logic [7:0] data);
      logic [10:0] size;
      logic [8:0]  sum;
      size = blk_long ? LONG_BLOCK : SHORT_BLOCK;
      case (rx_phase)
         PH_HEADER: begin
            if (data == BYTE_SOH || data == BYTE_STX) begin
               blk_long = (data == BYTE_STX);
               header_seen = 1'b1;
               blk_index = '0;
               crc_calc = '0;
               rx_phase = PH_NUMBER;
               note_reply(1'b0, 8'h00, 1'b0, 32'h0, 8'h00);
            end else if (data == BYTE_EOT) begin
               end_state = SESSION_DONE;
               rx_phase = PH_DONE;
               note_reply(1'b1, BYTE_ACK, 1'b0, 32'h0, 8'h00);
            end else if (data == BYTE_CAN) begin
               end_state = SESSION_ABORTED;
               rx_phase = PH_DONE;
               note_reply(1'b0, 8'h00, 1'b0, 32'h0, 8'h00);
            end else begin
               count_error();
            end
         end
         PH_NUMBER: begin
            hdr_number = data;
            rx_phase = PH_COMPL;
            note_reply(1'b0, 8'h00, 1'b0, 32'h0, 8'h00);
         end
         PH_COMPL: begin
            hdr_complement = data;
            rx_phase = PH_DATA;
            note_reply(1'b0, 8'h00, 1'b0, 32'h0, 8'h00);
         end
         PH_DATA: begin
            note_reply(1'b0, 8'h00, 1'b1, flash_addr + {21'b0, blk_index}, data);
            crc_calc = crc16_step(crc_calc, data);
            blk_index = blk_index + 11'd1;
            if (blk_index >= size)
               rx_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            crc_rx = {data, 8'h00};
            rx_phase = PH_CRC_LO;
            note_reply(1'b0, 8'h00, 1'b0, 32'h0, 8'h00);
         end
         PH_CRC_LO: begin
            crc_rx[7:0] = data;
            sum = {1'b0, hdr_number} + {1'b0, hdr_complement};
            if (hdr_number == next_number && sum == NUMBER_SUM && crc_rx == crc_calc) begin
               next_number = next_number + 8'd1;
               flash_addr = flash_addr + {21'b0, size};
               total_bytes = total_bytes + {21'b0, size};
               rx_phase = PH_HEADER;
               note_reply(1'b1, BYTE_ACK, 1'b0, 32'h0, 8'h00);
            end else begin
               count_error();
            end
         end
         default: note_reply(1'b0, 8'h00, 1'b0, 32'h0, 8'h00);
      endcase
   endfunction

   function automatic void predict_replies(input logic [1:0] mode, input logic [7:0] data);
      reply_type r;
      pending_n = 0;
      if (mode == MODE_START) begin
         restart_transfer();
         note_reply(1'b0, 8'h00, 1'b0, 32'h0, 8'h00);
      end else if (mode == MODE_UNUSED || end_state != SESSION_RUNNING ||
                   rx_phase == PH_DONE) begin
         note_reply(1'b0, 8'h00, 1'b0, 32'h0, 8'h00);
      end else if (mode == MODE_TIMEOUT) begin
         if (rx_phase == PH_HEADER && !header_seen) begin
            note_reply(1'b1, BYTE_ASK, 1'b0, 32'h0, 8'h00);
         end else begin
            rx_phase = PH_HEADER;
            count_error();
         end
      end else begin
         take_byte(data);
      end
      for (int k = 0; k < pending_n; k++) begin
         r = pending[k];
         r.session = end_state;
         r.file_size = total_bytes;
         r.last = (k == pending_n - 1);
         reply_queue.push_back(r);
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // any byte that is not a valid header
   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do
         b = rand_byte();
      while (b == BYTE_SOH || b == BYTE_STX || b == BYTE_EOT || b == BYTE_CAN);
      return b;
   endfunction

   function automatic block_fault_type pick_fault();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return FAULT_NONE;
      if (roll < 76)
         return FAULT_NUMBER;
      if (roll < 81)
         return FAULT_REPEAT;
      if (roll < 87)
         return FAULT_COMPLEMENT;
      if (roll < 93)
         return FAULT_CRC;
      return FAULT_TIMEOUT;
   endfunction

   task automatic send_request(input logic [1:0] mode, input logic [7:0] data);
      int gap;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_rx_byte <= data;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_replies(mode, data);
      request_count++;
      gap = gapless ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every reply has come back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (reply_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_BASE_ADDRESS)
         cfg_base = value;
      else
         cfg_max_errors = value[7:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_block(input bit long_blk, input block_fault_type fault);
      logic [7:0]  number;
      logic [7:0]  compl;
      logic [7:0]  data;
      logic [15:0] crc;
      logic [7:0]  frame [$];
      int          count;
      int          style;
      int          cut;
      number = next_number;
      compl = ~next_number;
      crc = '0;
      count = int'(long_blk ? LONG_BLOCK : SHORT_BLOCK);
      style = $urandom_range(0, 5);
      case (fault)
         FAULT_NUMBER: begin
            number = next_number ^ (8'h01 << $urandom_range(0, 7));
            compl = ~number;
         end
         FAULT_REPEAT: begin
            number = next_number - 8'd1;
            compl = ~number;
         end
         FAULT_COMPLEMENT: compl = ~number ^ (8'h01 << $urandom_range(0, 7));
         default: ;
      endcase
      frame.push_back(long_blk ? BYTE_STX : BYTE_SOH);
      frame.push_back(number);
      frame.push_back(compl);
      for (int i = 0; i < count; i++) begin
         data = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : rand_byte();
         crc = crc16_step(crc, data);
         frame.push_back(data);
      end
      if (fault == FAULT_CRC)
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame.push_back(crc[15:8]);
      frame.push_back(crc[7:0]);
      cut = $urandom_range(1, frame.size() - 1);
      for (int i = 0; i < frame.size(); i++) begin
         if (fault == FAULT_TIMEOUT && i == cut) begin
            send_request(MODE_TIMEOUT, rand_byte());
            break;
         end
         send_request(MODE_BYTE, frame[i]);
      end
   endtask

   task automatic run_random_transfers(input int target);
      int blocks;
      int roll;
      while (request_count < target) begin
         gapless = ($urandom_range(0, 4) == 0);
         send_request(MODE_START, rand_byte());
         repeat ($urandom_range(0, 2)) send_request(MODE_TIMEOUT, rand_byte());
         blocks = $urandom_range(1, 5);
         for (int b = 0; b < blocks && end_state == SESSION_RUNNING &&
              request_count < target; b++) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
               send_request(MODE_BYTE, junk_byte());
            else if (roll == 1)
               send_request(MODE_TIMEOUT, rand_byte());
            else if (roll == 2)
               send_request(MODE_UNUSED, rand_byte());
            if (end_state == SESSION_RUNNING)
               send_block(1'b0, pick_fault());
         end
         if (end_state == SESSION_RUNNING) begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
               send_request(MODE_BYTE, BYTE_EOT);
            else if (roll < 9)
               send_request(MODE_BYTE, BYTE_CAN);
         end
         if (end_state != SESSION_RUNNING && $urandom_range(0, 3) == 0)
            send_request($urandom_range(0, 1) ? MODE_BYTE : MODE_TIMEOUT, rand_byte());
      end
      gapless = 1'b0;
   endtask

   task automatic test_pre_block_timeouts();
      write_csr(CSR_BASE_ADDRESS, 32'h0000_4000);
      write_csr(CSR_MAX_ERRORS, 32'd3);
      send_request(MODE_TIMEOUT, 8'hFF);
      send_request(MODE_TIMEOUT, 8'h00);
      send_request(MODE_UNUSED, 8'hFF);
      send_request(MODE_START, 8'h00);
      send_request(MODE_TIMEOUT, 8'hA5);
   endtask

   task automatic test_header_errors();
      send_request(MODE_BYTE, 8'hFF);
      send_request(MODE_TIMEOUT, 8'h00);
      send_request(MODE_BYTE, BYTE_SOH);
      send_request(MODE_BYTE, 8'h01);
      send_request(MODE_TIMEOUT, 8'h00);
      // third error hits the limit
      send_request(MODE_TIMEOUT, 8'h00);
      send_request(MODE_BYTE, BYTE_SOH);
      send_request(MODE_TIMEOUT, 8'hFF);
      send_request(MODE_START, 8'hFF);
   endtask

   task automatic test_transfer_end();
      send_request(MODE_BYTE, BYTE_EOT);
      send_request(MODE_BYTE, BYTE_STX);
      send_request(MODE_START, 8'h00);
      send_request(MODE_BYTE, BYTE_CAN);
      send_request(MODE_TIMEOUT, 8'h00);
      send_request(MODE_START, 8'h00);
      // start request in the middle of a header
      send_request(MODE_BYTE, BYTE_STX);
      send_request(MODE_BYTE, 8'h01);
      send_request(MODE_START, 8'h00);
   endtask

   task automatic test_error_limits();
      settle();
      write_csr(CSR_MAX_ERRORS, 32'd1);
      send_request(MODE_START, 8'h00);
      send_request(MODE_BYTE, junk_byte());
      settle();
      write_csr(CSR_MAX_ERRORS, 32'd255);
      send_request(MODE_START, 8'h00);
      repeat (255) send_request(MODE_BYTE, junk_byte());
   endtask

   task automatic test_long_block();
      settle();
      // data addresses wrap past the top of the address space
      write_csr(CSR_BASE_ADDRESS, 32'hFFFF_FE80);
      write_csr(CSR_MAX_ERRORS, 32'd2);
      send_request(MODE_START, 8'h00);
      send_request(MODE_TIMEOUT, 8'h00);
      send_block(1'b1, FAULT_NONE);
      send_block(1'b0, FAULT_CRC);
      send_request(MODE_BYTE, BYTE_EOT);
   endtask

   task automatic test_random_transfers();
      int quota;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin
               write_csr(CSR_BASE_ADDRESS, 32'hFFFF_FFFF);
               write_csr(CSR_MAX_ERRORS, 32'd255);
            end
            1: begin
               write_csr(CSR_BASE_ADDRESS, 32'h0000_0000);
               write_csr(CSR_MAX_ERRORS, 32'd1);
            end
            default: begin
               write_csr(CSR_BASE_ADDRESS, $urandom);
               write_csr(CSR_MAX_ERRORS, $urandom_range(1, 255));
            end
         endcase
         quota = (ITEM_GOAL - request_count) / (PHASES - p);
         if (quota < 60)
            quota = 60;
         run_random_transfers(request_count + quota);
      end
   endtask

   // receiver side: ready streaks mixed with stalls
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         ready_hold <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 30);
      end
   end

   always @(posedge clock) begin : check_replies
      reply_type got;
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_tx_valid, rsp_tx_byte, rsp_wr_valid, rsp_wr_address, rsp_wr_data,
                rsp_session, rsp_file_size, rsp_last};
         if (reply_queue.size() == 0) begin
            if (mismatch_count < 10)
               $display("reply with no request pending: tx %0b/%h wr %0b/%h/%h", got.tx_valid,
                        got.tx_byte, got.wr_valid, got.wr_address, got.wr_data);
            mismatch_count++;
         end else begin
            want = reply_queue.pop_front();
            if (got !== want) begin
               if (mismatch_count < 10) begin
                  $display("reply mismatch at %0t", $realtime);
                  $display("  expected tx %0b/%h wr %0b/%h/%h session %0d size %0d last %0b",
                           want.tx_valid, want.tx_byte, want.wr_valid, want.wr_address,
                           want.wr_data, want.session, want.file_size, want.last);
                  $display("  actual   tx %0b/%h wr %0b/%h/%h session %0d size %0d last %0b",
                           got.tx_valid, got.tx_byte, got.wr_valid, got.wr_address,
                           got.wr_data, got.session, got.file_size, got.last);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      cfg_base = 32'h0;
      cfg_max_errors = 8'd3;
      restart_transfer();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pre_block_timeouts();
      test_header_errors();
      test_transfer_end();
      test_error_limits();
      test_long_block();
      test_random_transfers();
      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && reply_queue.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
